// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the heap core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap core assertion failed");
`define IPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap core assertion failed");
`else
`define IPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/ipq_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none
package ipq_pkg;

    localparam int ENTRIES   = 1024;
    localparam int SLOT_W    = 10;
    localparam int POS_W     = SLOT_W + 1;
    localparam int ID_W      = 10;
    localparam int KEY_HI_W  = 16;
    localparam int KEY_LO_W  = 64;
    localparam int KEY_W     = KEY_HI_W + KEY_LO_W;
    localparam int KEY_BYTES = KEY_W / 8;
    localparam int KEY_CHARS = 10;
    localparam int STAT_W    = 3;

    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_POP,
        KIND_MODIFY,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_ABSENT,
        ST_PRESENT
    } status_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_WIPE,
        DP_LOAD,
        DP_FAIL,
        DP_PUSH_INIT,
        DP_MOD_INIT,
        DP_POP_INIT,
        DP_POP_LAST,
        DP_POP_KEY,
        DP_UP_RD,
        DP_UP_KEY,
        DP_UP_MOVE,
        DP_DN_RD,
        DP_DN_KEY,
        DP_DN_KEY2,
        DP_DN_RCMP,
        DP_DN_MOVE,
        DP_PLACE,
        DP_CLR_RD,
        DP_CLR_WR,
        DP_CLR_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic id_zero;
        logic slot_hit;
        logic slot_bad;
        logic full;
        logic empty;
        logic at_root;
        logic moved;
        logic up_above;
        logic no_child;
        logic down_above;
        logic wipe_last;
        logic clr_end;
    } dp_flags_t;

    // Greater key wins; on equal keys the smaller id wins.
    function automatic logic ranks_above(
        input logic [KEY_W-1:0] a_key,
        input logic [ID_W-1:0]  a_id,
        input logic [KEY_W-1:0] b_key,
        input logic [ID_W-1:0]  b_id
    );
        logic res;
        if (a_key != b_key)
        begin
            res = (a_key > b_key);
        end
        else
        begin
            res = (a_id < b_id);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ipq_dpath.sv
// Heap datapath: slot, key and position memories plus sift registers.
`default_nettype none
module ipq_dpath
    import ipq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    input  wire logic [ID_W-1:0]     entry_id,
    input  wire logic [KEY_HI_W-1:0] key_high,
    input  wire logic [KEY_LO_W-1:0] key_low,
    output dp_flags_t                flags,
    output logic [ID_W-1:0]          popped_id,
    output logic [STAT_W-1:0]        status,
    output logic [SLOT_W-1:0]        entry_count
);

    function automatic logic [KEY_W-1:0] norm_key(
        input logic [KEY_HI_W-1:0] hi,
        input logic [KEY_LO_W-1:0] lo
    );
        logic [KEY_W-1:0] raw;
        logic [KEY_W-1:0] res;
        logic             ended;
        raw   = {hi, lo};
        res   = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (i >= KEY_CHARS || raw[KEY_W-1-8*i -: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                res[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
            end
        end
        return res;
    endfunction

    logic [ID_W-1:0]   heap_mem [ENTRIES];
    logic [KEY_W-1:0]  key_mem  [ENTRIES];
    logic [SLOT_W-1:0] slot_mem [ENTRIES];

    logic [ID_W-1:0]   heap_rd_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [SLOT_W-1:0] slot_rd_reg;

    logic [SLOT_W-1:0] len_reg, len_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              moved_reg, moved_next;
    status_t           status_reg, status_next;
    logic [ID_W-1:0]   popped_reg, popped_next;

    logic [POS_W-1:0]  cslot_reg, cslot_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [ID_W-1:0]   cur_id_reg, cur_id_next;
    logic [KEY_W-1:0]  cur_key_reg, cur_key_next;
    logic [ID_W-1:0]   par_id_reg, par_id_next;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [ID_W-1:0]   r_id_reg, r_id_next;

    logic              heap_re;
    logic [SLOT_W-1:0] heap_ra;
    logic              heap_we;
    logic [SLOT_W-1:0] heap_wa;
    logic [ID_W-1:0]   heap_wd;
    logic              slot_re;
    logic              slot_we;
    logic [ID_W-1:0]   slot_wa;
    logic [SLOT_W-1:0] slot_wd;
    logic              key_we;

    logic              has_right;
    logic              right_better;

    assign has_right    = (cslot_reg + POS_W'(1)) <= {1'b0, len_reg};
    assign right_better = ranks_above(key_rd_reg, r_id_reg, best_key_reg, best_id_reg);

    always_comb
    begin
        len_next      = len_reg;
        pos_next      = pos_reg;
        moved_next    = moved_reg;
        status_next   = status_reg;
        popped_next   = popped_reg;
        cslot_next    = cslot_reg;
        id_next       = id_reg;
        key_next      = key_reg;
        cur_id_next   = cur_id_reg;
        cur_key_next  = cur_key_reg;
        par_id_next   = par_id_reg;
        best_id_next  = best_id_reg;
        best_key_next = best_key_reg;
        r_id_next     = r_id_reg;
        heap_re       = 1'b0;
        heap_ra       = '0;
        heap_we       = 1'b0;
        heap_wa       = pos_reg[SLOT_W-1:0];
        heap_wd       = cur_id_reg;
        slot_re       = 1'b0;
        slot_we       = 1'b0;
        slot_wa       = cur_id_reg;
        slot_wd       = pos_reg[SLOT_W-1:0];
        key_we        = 1'b0;
        case (cmd.op)
            DP_WIPE:
            begin
                slot_we  = 1'b1;
                slot_wa  = pos_reg[SLOT_W-1:0];
                slot_wd  = '0;
                pos_next = pos_reg + POS_W'(1);
            end
            DP_LOAD:
            begin
                id_next     = entry_id;
                key_next    = norm_key(key_high, key_low);
                pos_next    = POS_W'(1);
                status_next = ST_OK;
                popped_next = '0;
                heap_re     = 1'b1;
                heap_ra     = SLOT_W'(1);
                slot_re     = 1'b1;
            end
            DP_FAIL:
            begin
                status_next = cmd.code;
            end
            DP_PUSH_INIT:
            begin
                len_next     = len_reg + SLOT_W'(1);
                pos_next     = {1'b0, len_reg} + POS_W'(1);
                cur_id_next  = id_reg;
                cur_key_next = key_reg;
                key_we       = 1'b1;
                moved_next   = 1'b0;
            end
            DP_MOD_INIT:
            begin
                pos_next     = {1'b0, slot_rd_reg};
                cur_id_next  = id_reg;
                cur_key_next = key_reg;
                key_we       = 1'b1;
                moved_next   = 1'b0;
            end
            DP_POP_INIT:
            begin
                popped_next = heap_rd_reg;
                slot_we     = 1'b1;
                slot_wa     = heap_rd_reg;
                slot_wd     = '0;
                len_next    = len_reg - SLOT_W'(1);
                // fetch the last entry before the length drops
                heap_re     = 1'b1;
                heap_ra     = len_reg;
            end
            DP_POP_LAST:
            begin
                cur_id_next = heap_rd_reg;
                pos_next    = POS_W'(1);
                moved_next  = 1'b0;
            end
            DP_POP_KEY:
            begin
                cur_key_next = key_rd_reg;
            end
            DP_UP_RD:
            begin
                heap_re = 1'b1;
                heap_ra = pos_reg[POS_W-1:1];
            end
            DP_UP_KEY:
            begin
                par_id_next = heap_rd_reg;
            end
            DP_UP_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wd    = par_id_reg;
                slot_we    = 1'b1;
                slot_wa    = par_id_reg;
                pos_next   = pos_reg >> 1;
                moved_next = 1'b1;
            end
            DP_DN_RD:
            begin
                heap_re    = 1'b1;
                heap_ra    = {pos_reg[SLOT_W-2:0], 1'b0};
                cslot_next = {pos_reg[SLOT_W-1:0], 1'b0};
            end
            DP_DN_KEY:
            begin
                best_id_next = heap_rd_reg;
                heap_re      = 1'b1;
                heap_ra      = cslot_reg[SLOT_W-1:0] + SLOT_W'(1);
            end
            DP_DN_KEY2:
            begin
                best_key_next = key_rd_reg;
                r_id_next     = heap_rd_reg;
            end
            DP_DN_RCMP:
            begin
                if (has_right && right_better)
                begin
                    best_id_next  = r_id_reg;
                    best_key_next = key_rd_reg;
                    cslot_next    = cslot_reg + POS_W'(1);
                end
            end
            DP_DN_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wd    = best_id_reg;
                slot_we    = 1'b1;
                slot_wa    = best_id_reg;
                pos_next   = cslot_reg;
                moved_next = 1'b1;
            end
            DP_PLACE:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            DP_CLR_RD:
            begin
                heap_re = 1'b1;
                heap_ra = pos_reg[SLOT_W-1:0];
            end
            DP_CLR_WR:
            begin
                slot_we  = 1'b1;
                slot_wa  = heap_rd_reg;
                slot_wd  = '0;
                pos_next = pos_reg + POS_W'(1);
            end
            DP_CLR_END:
            begin
                len_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            pos_reg    <= '0;
            moved_reg  <= 1'b0;
            status_reg <= ST_OK;
            popped_reg <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            moved_reg  <= moved_next;
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cslot_reg    <= cslot_next;
        id_reg       <= id_next;
        key_reg      <= key_next;
        cur_id_reg   <= cur_id_next;
        cur_key_reg  <= cur_key_next;
        par_id_reg   <= par_id_next;
        best_id_reg  <= best_id_next;
        best_key_reg <= best_key_next;
        r_id_reg     <= r_id_next;
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (heap_re)
        begin
            heap_rd_reg <= heap_mem[heap_ra];
        end
    end

    // key read follows the id fetched in the previous cycle
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[id_reg] <= key_reg;
        end
        key_rd_reg <= key_mem[heap_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[entry_id];
        end
    end

    always_comb
    begin
        flags.id_zero    = (id_reg == '0);
        flags.slot_hit   = (slot_rd_reg != '0);
        flags.slot_bad   = (slot_rd_reg == '0) || (slot_rd_reg > len_reg);
        flags.full       = ({1'b0, len_reg} >= POS_W'(ENTRIES - 1));
        flags.empty      = (len_reg == '0);
        flags.at_root    = (pos_reg == POS_W'(1));
        flags.moved      = moved_reg;
        flags.up_above   = ranks_above(cur_key_reg, cur_id_reg, key_rd_reg, par_id_reg);
        flags.no_child   = ({pos_reg[SLOT_W-1:0], 1'b0} > {1'b0, len_reg});
        flags.down_above = ranks_above(best_key_reg, best_id_reg, cur_key_reg, cur_id_reg);
        flags.wipe_last  = (pos_reg == POS_W'(ENTRIES - 1));
        flags.clr_end    = (pos_reg > {1'b0, len_reg});
    end

    assign popped_id   = popped_reg;
    assign status      = status_reg;
    assign entry_count = len_reg;

endmodule
`default_nettype wire

// File: rtl/core/ipq_ctrl.sv
// Heap controller: sequences push, pop, modify, clear and the reset wipe.
`default_nettype none
module ipq_ctrl
    import ipq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] kind,
    input  wire dp_flags_t  flags,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [3:0] {
        S_WIPE,
        S_IDLE,
        S_CHECK,
        S_UP_RD,
        S_UP_KEY,
        S_UP_CMP,
        S_DN_RD,
        S_DN_KEY,
        S_DN_KEY2,
        S_DN_RCMP,
        S_DN_CMP,
        S_POP_LAST,
        S_POP_KEY,
        S_CLR_RD,
        S_CLR_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd.op     = DP_NOP;
        cmd.code   = ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_WIPE:
            begin
                cmd.op = DP_WIPE;
                if (flags.wipe_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (flags.id_zero)
                        begin
                            cmd.op     = DP_FAIL;
                            cmd.code   = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else if (flags.slot_hit)
                        begin
                            cmd.op     = DP_FAIL;
                            cmd.code   = ST_PRESENT;
                            state_next = S_DONE;
                        end
                        else if (flags.full)
                        begin
                            cmd.op     = DP_FAIL;
                            cmd.code   = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = DP_PUSH_INIT;
                            state_next = S_UP_RD;
                        end
                    end
                    KIND_POP:
                    begin
                        if (flags.empty)
                        begin
                            cmd.op     = DP_FAIL;
                            cmd.code   = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = DP_POP_INIT;
                            state_next = S_POP_LAST;
                        end
                    end
                    KIND_MODIFY:
                    begin
                        if (flags.id_zero || flags.slot_bad)
                        begin
                            cmd.op     = DP_FAIL;
                            cmd.code   = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = DP_MOD_INIT;
                            state_next = S_UP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_CLR_RD;
                    end
                endcase
            end
            S_UP_RD, S_UP_CMP:
            begin
                if (state_reg == S_UP_RD && !flags.at_root)
                begin
                    cmd.op     = DP_UP_RD;
                    state_next = S_UP_KEY;
                end
                else if (state_reg == S_UP_CMP && flags.up_above)
                begin
                    cmd.op     = DP_UP_MOVE;
                    state_next = S_UP_RD;
                end
                else if (kind_reg == KIND_MODIFY && !flags.moved)
                begin
                    // entry did not rise: try sinking from the same slot
                    state_next = S_DN_RD;
                end
                else
                begin
                    cmd.op     = DP_PLACE;
                    state_next = S_DONE;
                end
            end
            S_UP_KEY:
            begin
                cmd.op     = DP_UP_KEY;
                state_next = S_UP_CMP;
            end
            S_DN_RD:
            begin
                if (flags.no_child)
                begin
                    cmd.op     = DP_PLACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_DN_RD;
                    state_next = S_DN_KEY;
                end
            end
            S_DN_KEY:
            begin
                cmd.op     = DP_DN_KEY;
                state_next = S_DN_KEY2;
            end
            S_DN_KEY2:
            begin
                cmd.op     = DP_DN_KEY2;
                state_next = S_DN_RCMP;
            end
            S_DN_RCMP:
            begin
                cmd.op     = DP_DN_RCMP;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (flags.down_above)
                begin
                    cmd.op     = DP_DN_MOVE;
                    state_next = S_DN_RD;
                end
                else
                begin
                    cmd.op     = DP_PLACE;
                    state_next = S_DONE;
                end
            end
            S_POP_LAST:
            begin
                cmd.op     = DP_POP_LAST;
                state_next = flags.empty ? S_DONE : S_POP_KEY;
            end
            S_POP_KEY:
            begin
                cmd.op     = DP_POP_KEY;
                state_next = S_DN_RD;
            end
            S_CLR_RD:
            begin
                if (flags.clr_end)
                begin
                    cmd.op     = DP_CLR_END;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_CLR_RD;
                    state_next = S_CLR_WR;
                end
            end
            S_CLR_WR:
            begin
                cmd.op     = DP_CLR_WR;
                state_next = S_CLR_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
            kind_reg  <= KIND_PUSH;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                kind_reg <= kind_t'(kind);
            end
            busy_reg <= (state_next != S_IDLE);
            done_reg <= (state_next == S_DONE);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// File: rtl/core/indexed_priority_heap_core.sv
// Top level of the indexed priority heap core.
`default_nettype none
`include "assert_macros.svh"
// Usage:
// A transaction is taken at a rising edge with start high and busy low; kind,
// entry_id, key_high and key_low are sampled then. kind selects push, pop,
// modify key or clear. Each transaction gives exactly one result: done is
// high for one cycle with popped_id, status and entry_count valid; the
// receiver must take it then, since it cannot stall the core.
// Sequence from start to done: a failed check goes straight to done. A push
// that starts at the root is placed directly; otherwise it reads its parent
// and rises one level each time it ranks above it. Sinking reads and compares
// both children at each level (one read each of the heap and key memories per
// cycle): a pop that empties the heap ends there, otherwise the last entry
// moves to the root and sinks until no child ranks above it or it has none.
// A modify that does not rise, at the root or below it, then sinks the same
// way. Clear frees the position of every stored entry, then empties the heap.
// One transaction is in flight at a time; busy stays high until after done.
// Reset: the position store is swept to absent, one entry a cycle, which
// holds busy high until the sweep ends; the heap is then empty.
module indexed_priority_heap_core
    import ipq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          kind,
    input  wire logic [ID_W-1:0]     entry_id,
    input  wire logic [KEY_HI_W-1:0] key_high,
    input  wire logic [KEY_LO_W-1:0] key_low,
    output logic                     done,
    output logic [ID_W-1:0]          popped_id,
    output logic [STAT_W-1:0]        status,
    output logic [SLOT_W-1:0]        entry_count
);

    dp_cmd_t   cmd;
    dp_flags_t flags;

    ipq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ipq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .entry_id    (entry_id),
        .key_high    (key_high),
        .key_low     (key_low),
        .flags       (flags),
        .popped_id   (popped_id),
        .status      (status),
        .entry_count (entry_count)
    );

    `IPQ_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `IPQ_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `IPQ_ASSERT_NEXT(a_idle_count, clk, rst_n, !busy, $stable(entry_count))
    `IPQ_ASSERT_IMPL(a_fail_no_id, clk, rst_n, done && status != ST_OK, popped_id == '0)

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the indexed priority heap core.
module testbench;
    import ipq_pkg::*;

    typedef struct packed {
        kind_t                kind;
        logic [ID_W-1:0]      entry_id;
        logic [KEY_HI_W-1:0]  key_high;
        logic [KEY_LO_W-1:0]  key_low;
    } heap_op_t;

    typedef struct packed {
        logic [ID_W-1:0]   popped_id;
        status_t           status;
        logic [SLOT_W-1:0] entry_count;
    } heap_res_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          kind;
    logic [ID_W-1:0]     entry_id;
    logic [KEY_HI_W-1:0] key_high;
    logic [KEY_LO_W-1:0] key_low;
    logic                done;
    logic [ID_W-1:0]     popped_id;
    logic [STAT_W-1:0]   status;
    logic [SLOT_W-1:0]   entry_count;

    heap_op_t  pending_ops[$];
    heap_res_t expected_results[$];
    int        error_count;
    int        ops_sent;
    int        pops_seen;
    int        idle_cycles;
    int        gap_left;
    bit        hold_sender;

    // shadow heap state
    logic [ID_W-1:0]     shadow_slots[ENTRIES];
    logic [KEY_W-1:0]    shadow_keys[ENTRIES];
    int unsigned         shadow_slot_of[ENTRIES];
    int unsigned         shadow_length;

    indexed_priority_heap_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .entry_id(entry_id), .key_high(key_high), .key_low(key_low),
        .done(done), .popped_id(popped_id), .status(status),
        .entry_count(entry_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit outranks(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        if (shadow_keys[a] != shadow_keys[b])
            return shadow_keys[a] > shadow_keys[b];
        return a < b;
    endfunction

    function automatic void swap_slots(int unsigned p, int unsigned q);
        logic [ID_W-1:0] t;
        t = shadow_slots[p];
        shadow_slots[p] = shadow_slots[q];
        shadow_slots[q] = t;
        shadow_slot_of[shadow_slots[p]] = p;
        shadow_slot_of[shadow_slots[q]] = q;
    endfunction

    function automatic int unsigned float_up(int unsigned p);
        while (p > 1 && outranks(shadow_slots[p], shadow_slots[p >> 1]))
        begin
            swap_slots(p, p >> 1);
            p = p >> 1;
        end
        return p;
    endfunction

    function automatic void sink_down(int unsigned p);
        int unsigned c;
        forever
        begin
            c = p << 1;
            if (c > shadow_length)
                break;
            if (c + 1 <= shadow_length && outranks(shadow_slots[c + 1], shadow_slots[c]))
                c++;
            if (!outranks(shadow_slots[c], shadow_slots[p]))
                break;
            swap_slots(p, c);
            p = c;
        end
    endfunction

    // truncate the key at its first zero byte or after KEY_CHARS characters
    function automatic logic [KEY_W-1:0] trim_key(logic [KEY_HI_W-1:0] hi,
                                                  logic [KEY_LO_W-1:0] lo);
        logic [KEY_W-1:0] k;
        bit ended;
        k = {hi, lo};
        ended = 1'b0;
        for (int i = KEY_BYTES - 1; i >= 0; i--)
        begin
            if (k[i*8 +: 8] == 8'd0 || (KEY_BYTES - 1 - i) >= KEY_CHARS)
                ended = 1'b1;
            if (ended)
                k[i*8 +: 8] = 8'd0;
        end
        return k;
    endfunction

    function automatic heap_res_t predict_heap_op(heap_op_t op);
        heap_res_t r;
        bit id_ok;
        int unsigned p;
        logic [ID_W-1:0] last;
        r = '{popped_id: '0, status: ST_OK, entry_count: '0};
        id_ok = op.entry_id != 0 && op.entry_id < ENTRIES;
        case (op.kind)
            KIND_PUSH:
            begin
                if (!id_ok)
                    r.status = ST_ABSENT;
                else if (shadow_slot_of[op.entry_id] != 0)
                    r.status = ST_PRESENT;
                else if (shadow_length >= ENTRIES - 1)
                    r.status = ST_FULL;
                else
                begin
                    shadow_length++;
                    shadow_slots[shadow_length] = op.entry_id;
                    shadow_slot_of[op.entry_id] = shadow_length;
                    shadow_keys[op.entry_id] = trim_key(op.key_high, op.key_low);
                    void'(float_up(shadow_length));
                end
            end
            KIND_POP:
            begin
                if (shadow_length == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    last = shadow_slots[shadow_length];
                    r.popped_id = shadow_slots[1];
                    shadow_slot_of[shadow_slots[1]] = 0;
                    shadow_length--;
                    if (shadow_length > 0)
                    begin
                        shadow_slots[1] = last;
                        shadow_slot_of[last] = 1;
                        sink_down(1);
                    end
                end
            end
            KIND_MODIFY:
            begin
                if (!id_ok || shadow_slot_of[op.entry_id] == 0)
                    r.status = ST_ABSENT;
                else
                begin
                    p = shadow_slot_of[op.entry_id];
                    shadow_keys[op.entry_id] = trim_key(op.key_high, op.key_low);
                    if (float_up(p) == p)
                        sink_down(p);
                end
            end
            default:
            begin
                for (int unsigned i = 1; i <= shadow_length; i++)
                    shadow_slot_of[shadow_slots[i]] = 0;
                shadow_length = 0;
            end
        endcase
        r.entry_count = shadow_length[SLOT_W-1:0];
        return r;
    endfunction

    // keys with a random number of characters, often colliding
    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        int len;
        k = KEY_W'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 3))
            0: k = k & {KEY_BYTES{8'h03}} | {KEY_BYTES{8'h40}};
            1:
            begin
                len = $urandom_range(0, KEY_BYTES);
                for (int i = 0; i < KEY_BYTES; i++)
                    if (i >= len)
                        k[(KEY_BYTES - 1 - i)*8 +: 8] = 8'd0;
            end
            default: ;
        endcase
        return k;
    endfunction

    function automatic heap_op_t make_op(kind_t k, int id, logic [KEY_W-1:0] key);
        heap_op_t op;
        op.kind = k;
        op.entry_id = id[ID_W-1:0];
        op.key_high = key[KEY_W-1 -: KEY_HI_W];
        op.key_low = key[KEY_LO_W-1:0];
        return op;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            kind <= KIND_PUSH;
            entry_id <= '0;
            key_high <= '0;
            key_low <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            // transaction taken; hold off for a random gap
            expected_results.push_back(predict_heap_op(heap_op_t'({kind, entry_id,
                                                                    key_high, key_low})));
            ops_sent <= ops_sent + 1;
            start <= 1'b0;
            gap_left <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_ops.size() > 0 && !hold_sender)
            begin
                heap_op_t op;
                op = pending_ops.pop_front();
                kind <= op.kind;
                entry_id <= op.entry_id;
                key_high <= op.key_high;
                key_low <= op.key_low;
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            heap_res_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("result with no transaction outstanding");
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (popped_id !== exp_r.popped_id)
                begin
                    $error("popped_id expected %0d actual %0d", exp_r.popped_id, popped_id);
                    error_count++;
                end
                if (status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, status);
                    error_count++;
                end
                if (entry_count !== exp_r.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d",
                           exp_r.entry_count, entry_count);
                    error_count++;
                end
                if (exp_r.popped_id != 0)
                    pops_seen++;
            end
        end
    end

    // watchdog: counts cycles with no transaction accepted either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_W-1:0] all_ones;
        int id_pool;
        int pick;
        all_ones = '1;
        error_count = 0;
        ops_sent = 0;
        pops_seen = 0;
        hold_sender = 1'b0;
        shadow_length = 0;
        for (int i = 0; i < ENTRIES; i++)
            shadow_slot_of[i] = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: guards, extremes, ties, truncation, modify both ways
        pending_ops.push_back(make_op(KIND_POP, 0, '0));
        pending_ops.push_back(make_op(KIND_PUSH, 0, all_ones));
        pending_ops.push_back(make_op(KIND_MODIFY, 5, all_ones));
        pending_ops.push_back(make_op(KIND_PUSH, 1023, all_ones));
        pending_ops.push_back(make_op(KIND_PUSH, 1023, '0));
        pending_ops.push_back(make_op(KIND_PUSH, 1, '0));
        pending_ops.push_back(make_op(KIND_PUSH, 2, all_ones));
        pending_ops.push_back(make_op(KIND_PUSH, 3, {16'h4100, 64'hFFFF_FFFF_FFFF_FFFF}));
        pending_ops.push_back(make_op(KIND_PUSH, 4, {16'h4100, 64'h0}));
        pending_ops.push_back(make_op(KIND_PUSH, 5, {16'h4142, 64'h4300_4400_0000_0000}));
        pending_ops.push_back(make_op(KIND_MODIFY, 1, all_ones));
        pending_ops.push_back(make_op(KIND_MODIFY, 1023, '0));
        pending_ops.push_back(make_op(KIND_MODIFY, 0, '0));
        pending_ops.push_back(make_op(KIND_POP, 0, '0));
        pending_ops.push_back(make_op(KIND_POP, 0, '0));
        pending_ops.push_back(make_op(KIND_POP, 0, '0));
        pending_ops.push_back(make_op(KIND_CLEAR, 0, '0));
        pending_ops.push_back(make_op(KIND_POP, 0, '0));
        pending_ops.push_back(make_op(KIND_PUSH, 9, {16'h00FF, 64'hFFFF_FFFF_FFFF_FFFF}));
        pending_ops.push_back(make_op(KIND_POP, 0, '0));
        pending_ops.push_back(make_op(KIND_CLEAR, 0, '0));

        // let the directed part drain
        wait (pending_ops.size() == 0);
        @(negedge clk);
        wait (!start && expected_results.size() == 0);

        // random: mostly pushes/modifies, alternating a small and the full id pool, some pops and noise
        for (int n = 0; n < 600; n++)
        begin
            id_pool = (n % 200 < 100) ? 40 : 1023;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                pending_ops.push_back(make_op(KIND_PUSH, $urandom_range(1, id_pool),
                                              rand_key()));
            else if (pick < 65)
                pending_ops.push_back(make_op(KIND_POP, $urandom_range(0, 1023),
                                              rand_key()));
            else if (pick < 88)
                pending_ops.push_back(make_op(KIND_MODIFY, $urandom_range(1, id_pool),
                                              rand_key()));
            else if (pick < 97)
                pending_ops.push_back(make_op(kind_t'($urandom_range(0, 2)),
                                              $urandom_range(0, 1023), rand_key()));
            else
                pending_ops.push_back(make_op(KIND_CLEAR, $urandom_range(0, 1023),
                                              rand_key()));
            if (n % 50 == 0)
                wait (pending_ops.size() < 4);
            // hold the sender with work queued until every result is back
            if (n == 300)
            begin
                hold_sender = 1'b1;
                @(negedge clk);
                wait (!start && expected_results.size() == 0);
                hold_sender = 1'b0;
            end
        end

        wait (pending_ops.size() == 0);
        @(negedge clk);
        wait (!start && expected_results.size() == 0);
        repeat (100) @(posedge clk);

        $display("Ran %0d heap transactions (push, pop, modify, clear, guard cases);",
                 ops_sent);
        $display("%0d pops returned an entry.", pops_seen);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
